### design/i2c_master_bit_sequencer_macros.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define I2CMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/i2cms_pkg.sv
package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int STEP_W        = 5;
   localparam int PHASE_W       = 2;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_SACK  = 3'd4,
      OP_RACK  = 3'd5
   } i2cms_op_type;

   localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

   typedef struct packed {
      logic                     cmd_valid;
      logic [2:0]               opcode;
      logic [BITS_PER_BYTE-1:0] write_byte;
      logic                     ack_value;
      logic                     sda_in;
   } i2cms_req_type;

   typedef struct packed {
      logic                     running;
      logic [2:0]               op;
      logic [STEP_W-1:0]        step;
      logic [PHASE_W-1:0]       phase;
      logic [BITS_PER_BYTE-1:0] shreg;
      logic                     ackr;
      logic                     scl;
      logic                     sda;
   } i2cms_state_type;

   typedef struct packed {
      logic                     scl_out;
      logic                     sda_out;
      logic                     busy_res;
      logic                     done_res;
      logic [BITS_PER_BYTE-1:0] read_byte;
      logic                     ack_seen;
   } i2cms_result_type;

   // Number of line actions in each command sequence.
   function automatic logic [STEP_W-1:0] seq_len(input logic [2:0] op);
      logic [STEP_W-1:0] len;
      unique case (op)
         OP_START: len = STEP_W'(4);
         OP_STOP:  len = STEP_W'(3);
         OP_WRITE: len = STEP_W'(3 * BITS_PER_BYTE);
         OP_READ:  len = STEP_W'(1 + 2 * BITS_PER_BYTE);
         OP_SACK:  len = STEP_W'(3);
         default:  len = STEP_W'(4);
      endcase
      return len;
   endfunction

endpackage

### design/i2cms_if.sv
interface i2cms_req_if;
   logic                               valid;
   logic                               ready;
   logic                               cmd_valid;
   logic [2:0]                         opcode;
   logic [i2cms_pkg::BITS_PER_BYTE-1:0] write_byte;
   logic                               ack_value;
   logic                               sda_in;

   modport source (output valid, cmd_valid, opcode, write_byte, ack_value, sda_in,
                   input ready);
   modport sink   (input valid, cmd_valid, opcode, write_byte, ack_value, sda_in,
                   output ready);
endinterface

interface i2cms_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               scl_out;
   logic                               sda_out;
   logic                               busy_res;
   logic                               done_res;
   logic [i2cms_pkg::BITS_PER_BYTE-1:0] read_byte;
   logic                               ack_seen;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte, ack_seen,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_byte, ack_seen,
                   output ready);
endinterface

### design/i2cms_action.sv
module i2cms_action (
   input  i2cms_pkg::i2cms_req_type    req,
   input  i2cms_pkg::i2cms_state_type  state,
   output i2cms_pkg::i2cms_state_type  state_next,
   output i2cms_pkg::i2cms_result_type result
);

   always_comb begin
      i2cms_pkg::i2cms_state_type nxt;
      i2cms_pkg::i2cms_result_type res;
      logic                         start;
      logic [i2cms_pkg::STEP_W-1:0] s;

      nxt   = state;
      res   = '0;
      start = !state.running && req.cmd_valid && (req.opcode <= i2cms_pkg::OP_RACK);

      // A command on an idle beat is loaded and its first action runs in the same beat.
      if (start) begin
         nxt.running = 1'b1;
         nxt.op      = req.opcode;
         nxt.step    = '0;
         nxt.phase   = '0;
         if (req.opcode == i2cms_pkg::OP_WRITE) begin
            nxt.shreg = req.write_byte;
         end else if (req.opcode == i2cms_pkg::OP_READ) begin
            nxt.shreg = '0;
         end
         if (req.opcode == i2cms_pkg::OP_SACK) begin
            nxt.ackr = req.ack_value;
         end
      end

      s = nxt.step;

      if (nxt.running) begin
         unique case (nxt.op)
            i2cms_pkg::OP_START: begin
               priority if (s == 0) nxt.sda = 1'b1;
               else if (s == 1)     nxt.scl = 1'b1;
               else if (s == 2)     nxt.sda = 1'b0;
               else                 nxt.scl = 1'b0;
            end
            i2cms_pkg::OP_STOP: begin
               priority if (s == 0) nxt.sda = 1'b0;
               else if (s == 1)     nxt.scl = 1'b1;
               else                 nxt.sda = 1'b1;
            end
            i2cms_pkg::OP_WRITE: begin
               // The phase counter tracks the step within each three-action bit.
               priority if (nxt.phase == 0) begin
                  nxt.sda = nxt.shreg[i2cms_pkg::BITS_PER_BYTE-1];
               end else if (nxt.phase == 1) begin
                  nxt.scl = 1'b1;
               end else begin
                  nxt.scl   = 1'b0;
                  nxt.shreg = {nxt.shreg[i2cms_pkg::BITS_PER_BYTE-2:0], 1'b0};
               end
            end
            i2cms_pkg::OP_READ: begin
               priority if (s == 0) begin
                  nxt.sda = 1'b1;
               end else if (s[0]) begin
                  nxt.scl = 1'b1;
               end else begin
                  nxt.scl   = 1'b0;
                  nxt.shreg = {nxt.shreg[i2cms_pkg::BITS_PER_BYTE-2:0], req.sda_in};
               end
            end
            i2cms_pkg::OP_SACK: begin
               priority if (s == 0) nxt.sda = nxt.ackr;
               else if (s == 1)     nxt.scl = 1'b1;
               else                 nxt.scl = 1'b0;
            end
            default: begin
               // Receive ack: the third action holds both lines.
               priority if (s == 0) begin
                  nxt.sda = 1'b1;
               end else if (s == 1) begin
                  nxt.scl = 1'b1;
               end else if (s == 3) begin
                  nxt.scl  = 1'b0;
                  nxt.ackr = req.sda_in;
               end else begin
               end
            end
         endcase

         nxt.step  = s + 1'b1;
         nxt.phase = (nxt.phase == i2cms_pkg::PHASE_LAST) ? '0 : nxt.phase + 1'b1;

         if (nxt.step >= i2cms_pkg::seq_len(nxt.op)) begin
            nxt.running  = 1'b0;
            res.done_res = 1'b1;
            if (nxt.op == i2cms_pkg::OP_READ) begin
               res.read_byte = nxt.shreg;
            end
            if (nxt.op == i2cms_pkg::OP_RACK) begin
               res.ack_seen = nxt.ackr;
            end
         end
      end

      res.scl_out  = nxt.scl;
      res.sda_out  = nxt.sda;
      res.busy_res = nxt.running;

      state_next = nxt;
      result     = res;
   end

endmodule

### design/i2c_master_bit_sequencer.sv
// A response beat is registered and valid in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle when not stalled; each beat is one line action,
// set by the single state register that the action logic updates on every accepted beat.
// A stalled response holds one beat in the output register and holds off requests.
// Reset (synchronous): idle, SCL and SDA released high, no response pending.
`include "i2c_master_bit_sequencer_macros.svh"

module i2c_master_bit_sequencer (
   input  logic         clock,
   input  logic         reset,
   i2cms_req_if.sink    req_chan,
   i2cms_rsp_if.source  rsp_chan
);

   i2cms_pkg::i2cms_req_type    req;
   i2cms_pkg::i2cms_state_type  state_ff;
   i2cms_pkg::i2cms_state_type  state_in;
   i2cms_pkg::i2cms_result_type result_ff;
   i2cms_pkg::i2cms_result_type result_in;
   logic                        rsp_valid_ff;
   logic                        accept;

   assign req.cmd_valid  = req_chan.cmd_valid;
   assign req.opcode     = req_chan.opcode;
   assign req.write_byte = req_chan.write_byte;
   assign req.ack_value  = req_chan.ack_value;
   assign req.sda_in     = req_chan.sda_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   i2cms_action u_action (
      .req        (req),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= '{scl: 1'b1, sda: 1'b1, default: '0};
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_out   = result_ff.scl_out;
   assign rsp_chan.sda_out   = result_ff.sda_out;
   assign rsp_chan.busy_res  = result_ff.busy_res;
   assign rsp_chan.done_res  = result_ff.done_res;
   assign rsp_chan.read_byte = result_ff.read_byte;
   assign rsp_chan.ack_seen  = result_ff.ack_seen;

   `I2CMS_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_valid_ff && result_ff.done_res, !result_ff.busy_res, "done beat reports busy")
   `I2CMS_ASSERT_NOW(a_step_in_range, clock, reset, state_ff.running, state_ff.step < i2cms_pkg::seq_len(state_ff.op), "step count past end of sequence")
   `I2CMS_ASSERT_NOW(a_phase_in_range, clock, reset, 1'b1, state_ff.phase != 2'd3, "bit phase out of range")
   `I2CMS_ASSERT_NOW(a_data_only_with_done, clock, reset, rsp_valid_ff && !result_ff.done_res, result_ff.read_byte == '0 && !result_ff.ack_seen, "read data without done")
   `I2CMS_ASSERT_NEXT(a_idle_lines_hold, clock, reset, accept && !state_ff.running && !(req.cmd_valid && req.opcode <= i2cms_pkg::OP_RACK), state_ff.scl == $past(state_ff.scl) && state_ff.sda == $past(state_ff.sda) && !state_ff.running, "lines moved on an idle beat")

endmodule
